FILE: sv/drc_pkg.sv
// Shared types and constants for the dynamic resolution controller.
package drc_pkg;

  // Field widths.
  localparam int SCALE_W    = 17;
  localparam int TIME_W     = 32;
  localparam int FPS_W      = 10;
  localparam int TARGET_W   = 20;
  localparam int PROD_W     = SCALE_W + TARGET_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Default history length.
  localparam int HISTORY_DEPTH_DEF = 3;

  // Scale constants in Q16.
  localparam logic [SCALE_W-1:0] FULL_SCALE    = 17'd65536;
  localparam logic [SCALE_W-1:0] STEP_UP_LIMIT = 17'd1966;
  localparam logic [SCALE_W-1:0] SNAP_LEVEL    = 17'd63570;
  localparam logic [SCALE_W-1:0] MIN_MOVE      = 17'd1311;
  localparam logic [SCALE_W-1:0] RESET_MIN     = 17'd32768;

  // Timing constants.
  localparam logic [TARGET_W-1:0] TIME_NUMERATOR = 20'd1000000;
  localparam logic [TIME_W-1:0]   HOLD_FRAMES    = 32'd5;
  localparam logic [TIME_W-1:0]   START_FRAME    = 32'd100;
  localparam logic [FPS_W-1:0]    RESET_FPS      = 10'd60;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE  = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV1,
    ST_MUL,
    ST_DIV2,
    ST_FIN,
    ST_DONE
  } drc_state_t;

endpackage

FILE: sv/drc_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module drc_serial_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_diff;
  logic             trial_ge;
  logic [DEN_W-1:0] rem_nxt;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial      = {rem_r, quo_r[NUM_W-1]};
    trial_ge   = (trial >= {1'b0, den_r});
    trial_diff = trial - {1'b0, den_r};
    rem_nxt    = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rem_r  <= '0;
      quo_r  <= num;
      den_r  <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], trial_ge};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

FILE: sv/dynamic_resolution_controller.sv
// Top level of the dynamic resolution controller.
//
// Usage: each input transfer on in_* carries the render time of one finished
// frame in microseconds. Each one yields exactly one output transfer on out_*
// with the render scale after that frame (Q16, 65536 = 1.0) and a flag that
// is set when this frame changed the scale.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle; the user must keep to this, as the block does not enforce it.
// Index 0 is enable, 1 is target_fps, 2 is minimum_scale.
// A frame inside the hold-off window or with the controller disabled goes
// from ST_SUM straight to ST_DONE and then to the output register. A frame
// that adapts the scale finds the average by a bit-serial divide over the
// history sum, then runs a 17-step shift-add multiply, then a 37-step
// bit-serial divide. One frame is worked on at a time; the next input is
// taken the cycle after the result loads, even while out_ready is low.
// If the receiver stalls with a result still held, a finished frame waits
// in its last state until the output register frees up.
// Reset (synchronous, active low) clears the history, the frame counter,
// sets the hold-off to frame 100 and the scale to full scale, and loads
// the register defaults.
module dynamic_resolution_controller
  import drc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_W-1:0]     in_gpu_time_us,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SCALE_W-1:0]    out_render_scale,
  output logic                  out_scale_changed,
  // Configuration port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W   = TIME_W + $clog2(HISTORY_DEPTH);
  localparam int MCNT_W  = $clog2(SCALE_W);

  // Configuration registers.
  logic               enable_r;
  logic [FPS_W-1:0]   target_fps_r;
  logic [SCALE_W-1:0] min_scale_r;

  // Frame state.
  logic [TIME_W-1:0]  hist_r [HISTORY_DEPTH];
  logic [SUM_W-1:0]   sum_r;
  logic [TIME_W-1:0]  frame_count_r;
  logic [TIME_W-1:0]  next_allowed_r;
  logic [SCALE_W-1:0] scale_now_r;
  logic               changed_r;

  // Serial multiply.
  logic [PROD_W-1:0]  mul_acc_r;
  logic [PROD_W-1:0]  mul_acc_nxt;
  logic [SCALE_W-1:0] mul_q_r;
  logic [MCNT_W-1:0]  mul_cnt_r;

  // Output register.
  logic               out_valid_r;
  logic [SCALE_W-1:0] out_scale_r;
  logic               out_changed_r;

  // Sequencer.
  drc_state_t state_r;
  drc_state_t state_nxt;
  logic       start_div1;
  logic       start_kdiv;
  logic       out_load;
  logic       hold;

  // Divider ports.
  logic [SUM_W-1:0]    sum_new;
  logic [FPS_W-1:0]    fps_eff;
  logic                avg_busy;
  logic [SUM_W-1:0]    avg_quo;
  logic [TIME_W-1:0]   avg;
  logic                tgt_busy;
  logic [TARGET_W-1:0] tgt_quo;
  logic                k_busy;
  logic [PROD_W-1:0]   k_quo;

  // Limit and clamp of the new scale.
  logic [SCALE_W:0]   k_lim_cap;
  logic [SCALE_W:0]   k_lim;
  logic [SCALE_W:0]   k_snap;
  logic [SCALE_W-1:0] lo;
  logic [SCALE_W:0]   k_lo;
  logic [SCALE_W-1:0] k_fin;
  logic [SCALE_W-1:0] k_diff;
  logic               apply;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      target_fps_r <= RESET_FPS;
      min_scale_r  <= RESET_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:     enable_r     <= cfg_data[0];
        REG_TARGET_FPS: target_fps_r <= cfg_data[FPS_W-1:0];
        REG_MIN_SCALE:  min_scale_r  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Operands of the first two divides.
  assign sum_new = sum_r + SUM_W'(hist_r[HISTORY_DEPTH-1]);
  assign fps_eff = (target_fps_r == '0) ? FPS_W'(1) : target_fps_r;
  assign avg     = avg_quo[TIME_W-1:0];
  assign hold    = (frame_count_r < next_allowed_r);

  // Average frame time over the history.
  drc_serial_div #(
    .NUM_W (SUM_W),
    .DEN_W (DEPTH_W)
  ) u_avg_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_div1),
    .num   (sum_new),
    .den   (DEPTH_W'(HISTORY_DEPTH)),
    .busy  (avg_busy),
    .quo   (avg_quo)
  );

  // Target frame time in microseconds.
  drc_serial_div #(
    .NUM_W (TARGET_W),
    .DEN_W (FPS_W)
  ) u_tgt_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_div1),
    .num   (TIME_NUMERATOR),
    .den   (fps_eff),
    .busy  (tgt_busy),
    .quo   (tgt_quo)
  );

  // Raw new scale: scale times target over average.
  drc_serial_div #(
    .NUM_W (PROD_W),
    .DEN_W (TIME_W)
  ) u_k_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_kdiv),
    .num   (mul_acc_nxt),
    .den   (avg),
    .busy  (k_busy),
    .quo   (k_quo)
  );

  // One multiplier bit per cycle, most significant first.
  assign mul_acc_nxt = {mul_acc_r[PROD_W-2:0], 1'b0}
                     + (mul_q_r[SCALE_W-1] ? PROD_W'(tgt_quo) : '0);

  // Step limit, snap to full scale, clamp, and the minimum move test.
  always_comb begin
    k_lim_cap = {1'b0, scale_now_r} + {1'b0, STEP_UP_LIMIT};
    if (k_quo > PROD_W'(k_lim_cap)) begin
      k_lim = k_lim_cap;
    end else begin
      k_lim = k_quo[SCALE_W:0];
    end
    k_snap = (k_lim >= {1'b0, SNAP_LEVEL}) ? {1'b0, FULL_SCALE} : k_lim;
    if (min_scale_r == '0) begin
      lo = SCALE_W'(1);
    end else if (min_scale_r > FULL_SCALE) begin
      lo = FULL_SCALE;
    end else begin
      lo = min_scale_r;
    end
    k_lo  = (k_snap < {1'b0, lo}) ? {1'b0, lo} : k_snap;
    k_fin = (k_lo > {1'b0, FULL_SCALE}) ? FULL_SCALE : k_lo[SCALE_W-1:0];
    k_diff = (scale_now_r >= k_fin) ? (scale_now_r - k_fin) : (k_fin - scale_now_r);
    apply  = (k_diff >= MIN_MOVE);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    start_div1 = 1'b0;
    start_kdiv = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (hold || !enable_r) begin
          state_nxt = ST_DONE;
        end else begin
          start_div1 = 1'b1;
          state_nxt  = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (!avg_busy && !tgt_busy) begin
          state_nxt = (avg == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_cnt_r == MCNT_W'(SCALE_W - 1)) begin
          start_kdiv = 1'b1;
          state_nxt  = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (!k_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Frame datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      sum_r          <= '0;
      frame_count_r  <= '0;
      next_allowed_r <= START_FRAME;
      scale_now_r    <= FULL_SCALE;
      changed_r      <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            // Drop the oldest time from the running sum and shift in the new one.
            sum_r <= sum_r - SUM_W'(hist_r[0]);
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
              hist_r[i] <= hist_r[i+1];
            end
            hist_r[HISTORY_DEPTH-1] <= in_gpu_time_us;
            changed_r <= 1'b0;
          end
        end
        ST_SUM: begin
          sum_r <= sum_new;
          if (!hold && !enable_r) begin
            scale_now_r <= FULL_SCALE;
            changed_r   <= (scale_now_r != FULL_SCALE);
          end
        end
        ST_DIV1: begin
          mul_acc_r <= '0;
          mul_q_r   <= scale_now_r;
          mul_cnt_r <= '0;
        end
        ST_MUL: begin
          mul_acc_r <= mul_acc_nxt;
          mul_q_r   <= {mul_q_r[SCALE_W-2:0], 1'b0};
          mul_cnt_r <= mul_cnt_r + 1'b1;
        end
        ST_FIN: begin
          if (apply) begin
            scale_now_r    <= k_fin;
            changed_r      <= 1'b1;
            next_allowed_r <= frame_count_r + HOLD_FRAMES;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            frame_count_r <= frame_count_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: holds one result while the next frame is taken in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_scale_r   <= scale_now_r;
      out_changed_r <= changed_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_render_scale  = out_scale_r;
  assign out_scale_changed = out_changed_r;

  // A transfer in starts the sequencer, so the input closes the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready right after a transfer");

  // A loaded result carries the scale that the frame left behind.
  a_result_matches_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && out_render_scale == $past(scale_now_r)))
    else $error("output register does not hold the frame's scale");

  // The scale only moves in the disable check or the final clamp step.
  a_scale_update_states: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ST_SUM || state_r == ST_FIN) |=> $stable(scale_now_r))
    else $error("scale changed outside its update states");

  // The hold-off frame moves only together with an applied scale change.
  a_holdoff_with_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(next_allowed_r)) |-> ($past(state_r) == ST_FIN && changed_r))
    else $error("hold-off frame moved without a scale change");

endmodule
